// File: rtl/dis_pkg.sv
// Shared types, sizes and codes for the disjoint interval set.
package dis_pkg;

	localparam int MAX_INTERVALS = 16;
	localparam int COORD_WIDTH   = 32;
	localparam int IDX_W         = $clog2(MAX_INTERVALS);
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

	typedef logic [COORD_WIDTH-1:0] coord_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	// input actions
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_ERASE  = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// commands broadcast to every cell
	localparam logic [2:0] OP_HOLD   = 3'd0;
	localparam logic [2:0] OP_INS_AT = 3'd1;
	localparam logic [2:0] OP_MERGE  = 3'd2;
	localparam logic [2:0] OP_ERASE  = 3'd3;
	localparam logic [2:0] OP_SPLIT  = 3'd4;
	localparam logic [2:0] OP_SHL    = 3'd5;

	typedef struct packed {
		logic   v;
		coord_t s;
		coord_t e;
	} entry_t;

	typedef struct packed {
		logic [2:0] op;
		idx_t       pos;
		coord_t     lo;
		coord_t     hi;
		coord_t     ns;
		coord_t     ne;
	} cmd_t;

	typedef struct packed {
		logic left;    // entry ends before lo
		logic mid;     // entry overlaps or touches [lo,hi)
		logic ovl;     // entry overlaps [lo,hi)
		logic cut_lo;  // entry starts below lo
		logic cut_hi;  // entry ends above hi
		logic hit;     // entry holds point lo
	} stat_t;

endpackage

// File: rtl/dis_cell.sv
// One table cell: holds an interval, classifies it and shifts with its neighbours.
module dis_cell import dis_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  idx_t   idx,
	input  cmd_t   cmd,
	input  entry_t lower,
	input  entry_t upper,
	input  coord_t psum_in,
	output entry_t ent,
	output stat_t  stat,
	output coord_t psum_out
);

	logic   v_q;
	coord_t s_q, e_q;
	coord_t psum_q;
	entry_t nxt;
	logic [IDX_W:0] pos_p1;

	assign ent = '{v: v_q, s: s_q, e: e_q};
	assign pos_p1 = {1'b0, cmd.pos} + 1'b1;

	// classify against the current range
	always_comb begin
		stat.left   = v_q && (e_q < cmd.lo);
		stat.mid    = v_q && !(e_q < cmd.lo) && !(s_q > cmd.hi);
		stat.ovl    = v_q && !((e_q <= cmd.lo) || (s_q >= cmd.hi));
		stat.cut_lo = s_q < cmd.lo;
		stat.cut_hi = e_q > cmd.hi;
		stat.hit    = v_q && (s_q <= cmd.lo) && (cmd.lo < e_q);
	end

	// work out the next content
	always_comb begin
		nxt = ent;
		case (cmd.op)
			OP_INS_AT: begin
				if (idx > cmd.pos) begin
					nxt = lower;
				end else if (idx == cmd.pos) begin
					nxt = '{v: 1'b1, s: cmd.ns, e: cmd.ne};
				end
			end
			OP_MERGE: begin
				if (stat.mid) begin
					if (idx == cmd.pos) begin
						nxt = '{v: 1'b1, s: cmd.ns, e: cmd.ne};
					end else begin
						nxt.v = 1'b0;
					end
				end
			end
			OP_ERASE: begin
				if (stat.ovl) begin
					if (stat.cut_lo) begin
						nxt.e = cmd.lo;
					end else if (stat.cut_hi) begin
						nxt.s = cmd.hi;
					end else begin
						nxt.v = 1'b0;
					end
				end
			end
			OP_SPLIT: begin
				if (idx == cmd.pos) begin
					nxt.e = cmd.lo;
				end else if ({1'b0, idx} == pos_p1) begin
					nxt = '{v: 1'b1, s: cmd.hi, e: lower.e};
				end else if ({1'b0, idx} > pos_p1) begin
					nxt = lower;
				end
			end
			OP_SHL: begin
				if (idx >= cmd.pos) begin
					nxt = upper;
				end
			end
			default: begin
				nxt = ent;
			end
		endcase
	end

	// hold the valid flag under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= nxt.v;
		end
	end

	// advance payload and the running length sum
	always_ff @(posedge clk) begin
		s_q    <= nxt.s;
		e_q    <= nxt.e;
		psum_q <= psum_in + (v_q ? (e_q - s_q) : '0);
	end

	assign psum_out = psum_q;

endmodule

// File: rtl/disjoint_interval_set.sv
// Top level of the disjoint interval set: sequencer, reductions and result register.
// Holds up to MAX_INTERVALS sorted, disjoint half-open intervals in a row of cells and
// takes one item at a time. A query, a rejected or empty range, or an unused action goes
// from the evaluate state straight to the done state. An insert or erase that changes
// the table runs the evaluate state, then S single-place left shifts (S from 0 to
// MAX_INTERVALS) that close the gaps left by merged or removed entries, then lets the
// running length sum ripple along the row of cells before the done state. The next
// item is taken as soon as the result sits in the output register.
module disjoint_interval_set import dis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] lo,
	input  logic [31:0] hi,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        contained,
	output logic [31:0] total_covered,
	output logic        table_full,
	output logic        bad_range
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] act_q;
	coord_t     lo_q, hi_q, total_q;
	cnt_t       cnt_q, nsh_q, sumc_q;
	idx_t       shpos_q;
	logic       res_cont_q, res_full_q, res_bad_q;
	logic       ov_q, oc_q, of_q, ob_q;
	coord_t     ot_q;

	cmd_t   cmd;
	entry_t ent [MAX_INTERVALS];
	stat_t  st [MAX_INTERVALS];
	coord_t psum [MAX_INTERVALS];

	logic [MAX_INTERVALS-1:0] mid_m, left_m, ovl_m, hole_m, split_m, hit_m, first_m, last_m;
	cnt_t   k_mid, n_hole, n_left;
	idx_t   first_mid, first_hole, first_split;
	coord_t s_first, e_last;
	logic [CNT_W:0] ins_cnt;

	logic [2:0] d_op;
	idx_t       d_pos, d_shpos;
	coord_t     d_ns, d_ne;
	cnt_t       d_cnt, d_nsh;
	logic       d_change, d_full, d_bad, d_cont;

	function automatic idx_t first_set(input logic [MAX_INTERVALS-1:0] m);
		idx_t r;
		r = '0;
		for (int i = MAX_INTERVALS - 1; i >= 0; i--) begin
			if (m[i]) r = idx_t'(i);
		end
		return r;
	endfunction

	// row of cells
	for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
		entry_t lower_e, upper_e;
		coord_t pin;
		if (g == 0) begin : g_first
			assign lower_e = '0;
			assign pin     = '0;
		end else begin : g_rest
			assign lower_e = ent[g-1];
			assign pin     = psum[g-1];
		end
		if (g == MAX_INTERVALS - 1) begin : g_last
			assign upper_e = '0;
		end else begin : g_inner
			assign upper_e = ent[g+1];
		end
		dis_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (idx_t'(g)),
			.cmd      (cmd),
			.lower    (lower_e),
			.upper    (upper_e),
			.psum_in  (pin),
			.ent      (ent[g]),
			.stat     (st[g]),
			.psum_out (psum[g])
		);
		assign mid_m[g]   = st[g].mid;
		assign left_m[g]  = st[g].left;
		assign ovl_m[g]   = st[g].ovl;
		assign hole_m[g]  = st[g].ovl && !st[g].cut_lo && !st[g].cut_hi;
		assign split_m[g] = st[g].ovl && st[g].cut_lo && st[g].cut_hi;
		assign hit_m[g]   = st[g].hit;
	end

	// reduce the cell flags
	always_comb begin
		k_mid       = cnt_t'($countones(mid_m));
		n_hole      = cnt_t'($countones(hole_m));
		n_left      = cnt_t'($countones(left_m));
		first_mid   = first_set(mid_m);
		first_hole  = first_set(hole_m);
		first_split = first_set(split_m);
		first_m     = mid_m & ~(mid_m << 1);
		last_m      = mid_m & ~(mid_m >> 1);
		s_first     = '0;
		e_last      = '0;
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			if (first_m[i]) s_first = s_first | ent[i].s;
			if (last_m[i])  e_last  = e_last | ent[i].e;
		end
		ins_cnt = {1'b0, cnt_q} + 1'b1 - {1'b0, k_mid};
	end

	// decide the edit for the held item
	always_comb begin
		d_op     = OP_HOLD;
		d_pos    = '0;
		d_shpos  = '0;
		d_ns     = lo_q;
		d_ne     = hi_q;
		d_cnt    = cnt_q;
		d_nsh    = '0;
		d_change = 1'b0;
		d_full   = 1'b0;
		d_bad    = 1'b0;
		d_cont   = 1'b0;
		case (act_q)
			ACT_QUERY: begin
				d_cont = |hit_m;
			end
			ACT_INSERT, ACT_ERASE: begin
				if (lo_q > hi_q) begin
					d_bad = 1'b1;
				end else if (lo_q < hi_q) begin
					if (act_q == ACT_INSERT) begin
						if (ins_cnt > (CNT_W + 1)'(MAX_INTERVALS)) begin
							d_full = 1'b1;
						end else if (k_mid == '0) begin
							d_change = 1'b1;
							d_op     = OP_INS_AT;
							d_pos    = idx_t'(n_left);
							d_cnt    = cnt_t'(ins_cnt);
						end else begin
							d_change = 1'b1;
							d_op     = OP_MERGE;
							d_pos    = first_mid;
							d_ns     = (s_first < lo_q) ? s_first : lo_q;
							d_ne     = (e_last > hi_q) ? e_last : hi_q;
							d_cnt    = cnt_t'(ins_cnt);
							d_nsh    = k_mid - 1'b1;
							d_shpos  = first_mid + 1'b1;
						end
					end else if (|split_m) begin
						if (cnt_q == cnt_t'(MAX_INTERVALS)) begin
							d_full = 1'b1;
						end else begin
							d_change = 1'b1;
							d_op     = OP_SPLIT;
							d_pos    = first_split;
							d_cnt    = cnt_q + 1'b1;
						end
					end else if (|ovl_m) begin
						d_change = 1'b1;
						d_op     = OP_ERASE;
						d_cnt    = cnt_q - n_hole;
						d_nsh    = n_hole;
						d_shpos  = first_hole;
					end
				end
			end
			default: begin
				d_op = OP_HOLD;
			end
		endcase
	end

	// drive the cell command
	always_comb begin
		cmd.op  = OP_HOLD;
		cmd.pos = d_pos;
		cmd.lo  = lo_q;
		cmd.hi  = hi_q;
		cmd.ns  = d_ns;
		cmd.ne  = d_ne;
		case (state_q)
			ST_EVAL: begin
				cmd.op = d_op;
			end
			ST_SHIFT: begin
				cmd.op  = OP_SHL;
				cmd.pos = shpos_q;
			end
			default: begin
				cmd.op = OP_HOLD;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// sequence one item through the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			total_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			// hold a stalled result, raise a new one once the item is done
			ov_q <= (ov_q && out_stall) || (state_q == ST_DONE);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					cnt_q  <= d_cnt;
					sumc_q <= '0;
					nsh_q  <= d_nsh;
					if (!d_change) begin
						state_q <= ST_DONE;
					end else if (d_nsh != '0) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_SHIFT: begin
					nsh_q <= nsh_q - 1'b1;
					if (nsh_q == cnt_t'(1)) state_q <= ST_SUM;
				end
				ST_SUM: begin
					sumc_q <= sumc_q + 1'b1;
					if (sumc_q == cnt_t'(MAX_INTERVALS)) begin
						total_q <= psum[MAX_INTERVALS-1];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!ov_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the item, result flags and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			act_q <= action;
			lo_q  <= lo;
			hi_q  <= hi;
		end
		if (state_q == ST_EVAL) begin
			res_cont_q <= d_cont;
			res_full_q <= d_full;
			res_bad_q  <= d_bad;
			shpos_q    <= d_shpos;
		end
		if (state_q == ST_DONE && (!ov_q || !out_stall)) begin
			oc_q <= res_cont_q;
			of_q <= res_full_q;
			ob_q <= res_bad_q;
			ot_q <= total_q;
		end
	end

	assign out_valid     = ov_q;
	assign contained     = oc_q;
	assign table_full    = of_q;
	assign bad_range     = ob_q;
	assign total_covered = ot_q;

endmodule

// File: rtl/dis_checker.sv
// Port-level checks for the disjoint interval set, bound to the top level.
module dis_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        contained,
	input logic        table_full,
	input logic        bad_range
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a result carries at most one of its rejection flags
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(table_full && bad_range))
		else $error("both rejection flags set");

	// a covered point never comes with a rejection
	a_cont_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && contained |-> !table_full && !bad_range)
		else $error("containment with rejection flag");

	// one item at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

endmodule

bind disjoint_interval_set dis_checker u_dis_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.contained  (contained),
	.table_full (table_full),
	.bad_range  (bad_range)
);

// File: tb/sv/disjoint_interval_set_chk.sv
// Checker for the disjoint interval set: predicts each result and compares it.
module disjoint_interval_set_chk import dis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] lo,
	input  logic [31:0] hi,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        contained,
	input  logic [31:0] total_covered,
	input  logic        table_full,
	input  logic        bad_range,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        contained;
		logic [31:0] total;
		logic        full;
		logic        bad;
	} verdict_t;

	// shadow of the interval table
	logic [31:0] span_lo [MAX_INTERVALS];
	logic [31:0] span_hi [MAX_INTERVALS];
	int          span_n;
	logic [31:0] cover_sum;
	verdict_t    awaited [$];

	// build table: up to MAX_INTERVALS+1 candidates
	logic [31:0] cand_lo [MAX_INTERVALS+1];
	logic [31:0] cand_hi [MAX_INTERVALS+1];

	function automatic void commit_table(input int n);
		logic [63:0] sum;
		sum = 0;
		for (int i = 0; i < n; i++) begin
			span_lo[i] = cand_lo[i];
			span_hi[i] = cand_hi[i];
			sum += cand_hi[i] - cand_lo[i];
		end
		span_n = n;
		cover_sum = sum[31:0];
	endfunction

	function automatic bit unite(input logic [31:0] l, input logic [31:0] r);
		int n;
		bit placed;
		logic [31:0] ns, ne;
		n = 0;
		placed = 0;
		ns = l;
		ne = r;
		for (int i = 0; i < span_n; i++) begin
			if (span_hi[i] < l) begin
				cand_lo[n] = span_lo[i]; cand_hi[n] = span_hi[i]; n++;
			end else if (span_lo[i] > r) begin
				if (!placed) begin
					cand_lo[n] = ns; cand_hi[n] = ne; n++;
					placed = 1;
				end
				if (n > MAX_INTERVALS) return 0;
				cand_lo[n] = span_lo[i]; cand_hi[n] = span_hi[i]; n++;
			end else begin
				if (span_lo[i] < ns) ns = span_lo[i];
				if (span_hi[i] > ne) ne = span_hi[i];
			end
			if (n > MAX_INTERVALS) return 0;
		end
		if (!placed) begin
			if (n >= MAX_INTERVALS + 1) return 0;
			cand_lo[n] = ns; cand_hi[n] = ne; n++;
		end
		if (n > MAX_INTERVALS) return 0;
		commit_table(n);
		return 1;
	endfunction

	function automatic bit carve(input logic [31:0] l, input logic [31:0] r);
		int n;
		n = 0;
		for (int i = 0; i < span_n; i++) begin
			if (span_hi[i] <= l || span_lo[i] >= r) begin
				cand_lo[n] = span_lo[i]; cand_hi[n] = span_hi[i]; n++;
			end else begin
				if (span_lo[i] < l) begin
					cand_lo[n] = span_lo[i]; cand_hi[n] = l; n++;
				end
				if (span_hi[i] > r) begin
					if (n > MAX_INTERVALS) return 0;
					cand_lo[n] = r; cand_hi[n] = span_hi[i]; n++;
				end
			end
			if (n > MAX_INTERVALS) return 0;
		end
		commit_table(n);
		return 1;
	endfunction

	function automatic verdict_t predict_result(input logic [1:0] act,
			input logic [31:0] l, input logic [31:0] r);
		verdict_t v;
		v = '0;
		if (act == ACT_QUERY) begin
			for (int i = 0; i < span_n; i++)
				if (span_lo[i] <= l && l < span_hi[i]) v.contained = 1;
		end else if (act == ACT_INSERT || act == ACT_ERASE) begin
			if (l > r) v.bad = 1;
			else if (l < r)
				v.full = !((act == ACT_INSERT) ? unite(l, r) : carve(l, r));
		end
		v.total = cover_sum;
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			span_n = 0;
			cover_sum = 0;
			fail_count = 0;
			awaited.delete();
			pending = 0;
		end else begin
			if (in_valid && !in_stall)
				awaited.push_back(predict_result(action, lo, hi));
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = awaited.pop_front();
					if (contained !== want.contained)
						report_mismatch($sformatf("contained %b want %b",
							contained, want.contained));
					if (total_covered !== want.total)
						report_mismatch($sformatf("total_covered %h want %h",
							total_covered, want.total));
					if (table_full !== want.full)
						report_mismatch($sformatf("table_full %b want %b",
							table_full, want.full));
					if (bad_range !== want.bad)
						report_mismatch($sformatf("bad_range %b want %b",
							bad_range, want.bad));
				end
			end
			pending = awaited.size();
		end
	end

endmodule

// File: tb/sv/disjoint_interval_set_tb.sv
// Testbench top for the disjoint interval set: stimulus, idling and verdict.
module disjoint_interval_set_tb import dis_pkg::*;;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [31:0] lo;
	logic [31:0] hi;
	logic        out_valid;
	logic        out_stall;
	logic        contained;
	logic [31:0] total_covered;
	logic        table_full;
	logic        bad_range;
	int          fail_count;
	int          pending;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	disjoint_interval_set dut (.*);

	disjoint_interval_set_chk chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// stop a hung run
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 600000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// receiver stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// offer one transfer and hold it until taken
	task automatic send_item(input logic [1:0] act, input logic [31:0] l,
			input logic [31:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		lo       <= l;
		hi       <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// random range: mostly in a small window so entries meet and split
	task automatic send_random;
		logic [1:0]  act;
		logic [31:0] a, b;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) act = ACT_INSERT;
		else if (pick < 75) act = ACT_ERASE;
		else if (pick < 95) act = ACT_QUERY;
		else act = 2'd3;
		if ($urandom_range(9) < 8) begin
			a = $urandom_range(300);
			b = a + $urandom_range(12);
			if ($urandom_range(19) == 0) b = a - $urandom_range(1, 5);
		end else begin
			a = $urandom;
			b = $urandom;
			if ($urandom_range(1) && a > b) begin
				a = a ^ b; b = a ^ b; a = a ^ b;
			end
		end
		send_item(act, a, b);
	endtask

	initial begin
		in_valid = 0;
		action = ACT_INSERT;
		lo = 0;
		hi = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, flags and every action
		send_item(ACT_QUERY, 32'd0, 32'd0);
		send_item(ACT_INSERT, 32'd5, 32'd5);
		send_item(ACT_INSERT, 32'd9, 32'd3);
		send_item(ACT_ERASE, 32'hFFFFFFFF, 32'd0);
		send_item(ACT_INSERT, 32'd0, 32'hFFFFFFFF);
		send_item(ACT_QUERY, 32'hFFFFFFFE, 32'd0);
		send_item(ACT_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(ACT_INSERT, 32'd10, 32'd20);
		send_item(ACT_ERASE, 32'd100, 32'd200);
		send_item(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(ACT_ERASE, 32'd0, 32'hFFFFFFFF);
		// fill with sixteen entries, then overflow by insert and by split
		for (int k = 0; k < 16; k++)
			send_item(ACT_INSERT, 32'(k * 10), 32'(k * 10 + 5));
		send_item(ACT_INSERT, 32'd500, 32'd510);
		send_item(ACT_ERASE, 32'd1, 32'd2);
		send_item(ACT_INSERT, 32'd2, 32'd4);
		send_item(ACT_INSERT, 32'd5, 32'd10);
		send_item(ACT_ERASE, 32'd0, 32'hFFFFFFFF);

		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 24 : 0;
			recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 24 : 0;
			for (int k = 0; k < 500; k++) send_random();
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
